// File: rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared widths, codes and character helpers for the path canonicalizer.
// ----------------------------------------------------------------------------
package pcc_pkg;

   // Default sizes of the stores.
   localparam int DEF_PATH_BYTES = 512;
   localparam int DEF_MAX_ROOTS  = 8;
   localparam int DEF_ROOT_BYTES = 64;

   // Field widths of the channels.
   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int SLOT_W     = 3;
   localparam int POS_W      = 9;
   localparam int VERDICT_W  = 3;
   localparam int CLEN_W     = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam int RCOUNT_W   = 4;
   localparam int OCAP_W     = 10;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PATH   = 2'd0;
   localparam logic [OP_W-1:0] OP_ROOT   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ROOT_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_CAPACITY = 2'd1;

   localparam logic [OCAP_W-1:0] OUT_CAPACITY_RESET = 10'd512;

   // Result kinds.
   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] ERR_NONE        = 3'd0;
   localparam logic [VERDICT_W-1:0] ERR_NOT_ABS     = 3'd1;
   localparam logic [VERDICT_W-1:0] ERR_BAD_BYTE    = 3'd2;
   localparam logic [VERDICT_W-1:0] ERR_DOT_SPACE   = 3'd3;
   localparam logic [VERDICT_W-1:0] ERR_TOO_LONG    = 3'd4;
   localparam logic [VERDICT_W-1:0] ERR_REFUSED     = 3'd5;
   localparam logic [VERDICT_W-1:0] ERR_UNCONTAINED = 3'd6;
   localparam logic [VERDICT_W-1:0] ERR_TRUNCATED   = 3'd7;

   // Characters.
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LOW    = 8'h20;
   localparam logic [7:0] CH_HIGH   = 8'h80;

   // Number of refused prefixes and the length of the refused basename.
   localparam int PFX_COUNT   = 4;
   localparam int AUDIT_LEN   = 9;
   localparam int REF_LAST    = 5;

   // Fold an upper-case letter to lower case.
   function automatic logic [7:0] to_lower(input logic [7:0] c);
      to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   // ASCII from space up to 0x7F, without backslash or colon.
   function automatic logic byte_allowed(input logic [7:0] b);
      byte_allowed = (b >= CH_LOW) && (b < CH_HIGH) && (b != CH_BSLASH) && (b != CH_COLON);
   endfunction

   // Length of a refused prefix.
   function automatic logic [2:0] pfx_len(input logic [1:0] k);
      pfx_len = (k == 2'd1 || k == 2'd3) ? 3'd5 : 3'd4;
   endfunction

   // Byte i of a refused prefix: /dev, /proc, /sys, /boot.
   function automatic logic [7:0] pfx_byte(input logic [1:0] k, input logic [2:0] i);
      logic [39:0] s;
      unique case (k)
         2'd0: s = {"/dev", 8'h00};
         2'd1: s = "/proc";
         2'd2: s = {"/sys", 8'h00};
         2'd3: s = "/boot";
         default: s = '0;
      endcase
      pfx_byte = (i < 3'd5) ? s[8*(4 - int'(i)) +: 8] : 8'h00;
   endfunction

   // Byte k of the refused tail: a slash followed by the basename audit.log.
   function automatic logic [7:0] audit_byte(input logic [3:0] k);
      logic [79:0] s;
      s = "/audit.log";
      audit_byte = (k <= 4'd9) ? s[8*(9 - int'(k)) +: 8] : 8'h00;
   endfunction

endpackage

// File: rtl/pcc_chan_if.sv
// ----------------------------------------------------------------------------
// pcc_chan_if
// Valid/ready channels of the path canonicalizer: request, response, CSR.
// ----------------------------------------------------------------------------
interface pcc_req_if import pcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   logic [SLOT_W-1:0] root_slot;
   logic [POS_W-1:0]  position;

   modport source (output valid, operation, data_byte, last_byte, root_slot, position,
                   input ready);
   modport sink   (input valid, operation, data_byte, last_byte, root_slot, position,
                   output ready);
endinterface

interface pcc_rsp_if import pcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 result_kind;
   logic [VERDICT_W-1:0] verdict;
   logic [CLEN_W-1:0]    canon_length;
   logic [BYTE_W-1:0]    read_byte;

   modport source (output valid, result_kind, verdict, canon_length, read_byte,
                   input ready);
   modport sink   (input valid, result_kind, verdict, canon_length, read_byte,
                   output ready);
endinterface

interface pcc_csr_if import pcc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pcc_ram.sv
// ----------------------------------------------------------------------------
// pcc_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the old data on a same-address write; read data registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/path_canonicalize_and_contain_unit.sv
// ----------------------------------------------------------------------------
// path_canonicalize_and_contain_unit
// Absolute path canonicalizer with a refusal list and root containment.
// ----------------------------------------------------------------------------
// The request channel carries one word per operation: a path byte, a root
// table byte, or a read of a canonical byte. A path word with last_byte set
// produces one verdict word on the response channel; a read produces one
// read word; root writes and unused codes produce nothing. The CSR channel
// writes root_count and out_capacity and is always ready.
// The unit works on one word at a time and is not ready until the word is
// done and its response, if any, has been taken. A plain path byte passes
// through EXEC and POST, a slash also through FIN, a root write only through
// EXEC; a read goes through EXEC and RDW to OUT. A ".." segment walks back
// through the canonical RAM, reading and checking one popped byte at a time.
// The final checks of a path run the refusal scan, then the basename tail,
// then compare byte by byte against each loaded root; the single canonical
// RAM read port and the root RAM read port pace these steps. A stalled
// response holds its word and the unit stays busy. Reset returns the
// canonical path to "/", clears the path state and root_count and sets
// out_capacity to 512; the root table is undefined until written.
// ----------------------------------------------------------------------------
module path_canonicalize_and_contain_unit import pcc_pkg::*; #(
   parameter int PATH_BYTES = DEF_PATH_BYTES,
   parameter int MAX_ROOTS  = DEF_MAX_ROOTS,
   parameter int ROOT_BYTES = DEF_ROOT_BYTES
) (
   input  logic      clock,
   input  logic      reset,
   pcc_req_if.sink   req_ch,
   pcc_rsp_if.source rsp_ch,
   pcc_csr_if.sink   csr_ch
);

   localparam int PW   = $clog2(PATH_BYTES);
   localparam int LW   = PW + 1;
   localparam int SW   = PW + 2;
   localparam int RAW  = $clog2(MAX_ROOTS * ROOT_BYTES);
   localparam int RIW  = $clog2(ROOT_BYTES + 1);
   localparam int XW   = (PW > RIW) ? PW : RIW;
   localparam int BW   = $clog2(MAX_ROOTS * ROOT_BYTES + 1);
   localparam int RCW  = $clog2(MAX_ROOTS + 1);
   localparam int CW   = (PW > OCAP_W) ? PW : OCAP_W;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_RDW, S_FIN, S_POP_RD, S_POP_CHK, S_POST, S_FINAL,
      S_VERD, S_REF_RD, S_REF_CHK, S_AUD_RD, S_AUD_CHK, S_CON_RD, S_CON_CHK, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // Latched request word.
   logic [OP_W-1:0]   op_ff, op_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   // Path state.
   logic [PW-1:0]        canon_len_ff, canon_len_in;
   logic [LW-1:0]        seg_start_ff, seg_start_in;
   logic [LW-1:0]        seg_len_ff, seg_len_in;
   logic [VERDICT_W-1:0] pend_ff, pend_in;
   logic                 at_start_ff, at_start_in;
   logic [7:0]           seg_first_ff, seg_first_in;
   logic [7:0]           seg_second_ff, seg_second_in;
   logic [7:0]           seg_last_ff, seg_last_in;
   logic                 fin_ret_ff, fin_ret_in;

   // Scan state.
   logic [XW-1:0]          idx_ff, idx_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [PFX_COUNT-1:0]   alive_ff, alive_in;
   logic                   refused_ff, refused_in;
   logic [RCW-1:0]         root_ff, root_in;
   logic [BW-1:0]          base_ff, base_in;
   logic                   addr0_ff, addr0_in;

   // Response word.
   logic                 kind_ff, kind_in;
   logic [VERDICT_W-1:0] verdict_ff, verdict_in;
   logic [BYTE_W-1:0]    rdata_ff, rdata_in;

   // Registers.
   logic [RCOUNT_W-1:0] root_count_ff, root_count_in;
   logic [OCAP_W-1:0]   out_cap_ff, out_cap_in;

   // RAM ports.
   logic          c_we;
   logic [PW-1:0] c_waddr, c_raddr;
   logic [7:0]    c_wdata, c_rdata, canon_q;
   logic          r_we;
   logic [RAW-1:0] r_waddr, r_raddr;
   logic [7:0]    r_rdata;

   // Scratch values of the sequencer.
   logic [LW-1:0] new_start, eff_start;
   logic [SW-1:0] wsum, fsum;
   logic          in_range, ref_now;
   logic [RCW-1:0] n_roots;
   state_type     fin_ret_state;

   pcc_ram #(.WIDTH(8), .DEPTH(PATH_BYTES)) u_canon_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (c_raddr),
      .rd_data (c_rdata)
   );

   pcc_ram #(.WIDTH(8), .DEPTH(MAX_ROOTS * ROOT_BYTES)) u_root_ram (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (byte_ff),
      .rd_addr (r_raddr),
      .rd_data (r_rdata)
   );

   // Byte 0 of the canonical path is always the root slash.
   assign canon_q = addr0_ff ? CH_SLASH : c_rdata;

   assign n_roots = (int'(root_count_ff) > MAX_ROOTS) ? RCW'(MAX_ROOTS) : RCW'(root_count_ff);
   assign fin_ret_state = fin_ret_ff ? S_VERD : S_POST;

   // Channel outputs.
   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = (state_ff == S_OUT);
   assign rsp_ch.result_kind  = kind_ff;
   assign rsp_ch.verdict      = verdict_ff;
   assign rsp_ch.canon_length = CLEN_W'(canon_len_ff);
   assign rsp_ch.read_byte    = rdata_ff;
   assign csr_ch.ready        = 1'b1;

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      pos_in        = pos_ff;
      canon_len_in  = canon_len_ff;
      seg_start_in  = seg_start_ff;
      seg_len_in    = seg_len_ff;
      pend_in       = pend_ff;
      at_start_in   = at_start_ff;
      seg_first_in  = seg_first_ff;
      seg_second_in = seg_second_ff;
      seg_last_in   = seg_last_ff;
      fin_ret_in    = fin_ret_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      alive_in      = alive_ff;
      refused_in    = refused_ff;
      root_in       = root_ff;
      base_in       = base_ff;
      kind_in       = kind_ff;
      verdict_in    = verdict_ff;
      rdata_in      = rdata_ff;
      root_count_in = root_count_ff;
      out_cap_in    = out_cap_ff;
      c_we          = 1'b0;
      c_waddr       = '0;
      c_wdata       = CH_SLASH;
      c_raddr       = '0;
      r_we          = 1'b0;
      r_waddr       = '0;
      r_raddr       = '0;
      new_start     = (canon_len_ff > PW'(1)) ? LW'(canon_len_ff) + LW'(1) : LW'(1);
      eff_start     = (seg_len_ff == '0) ? new_start : seg_start_ff;
      wsum          = SW'(eff_start) + SW'(seg_len_ff);
      fsum          = SW'(seg_start_ff) + SW'(seg_len_ff);
      in_range      = XW'(canon_len_ff) > idx_ff;
      ref_now       = refused_ff;

      // Configuration writes.
      if (csr_ch.valid) begin
         if (csr_ch.index == REG_ROOT_COUNT) begin
            root_count_in = csr_ch.data[RCOUNT_W-1:0];
         end else if (csr_ch.index == REG_OUT_CAPACITY) begin
            out_cap_in = csr_ch.data[OCAP_W-1:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.operation;
               byte_in  = req_ch.data_byte;
               last_in  = req_ch.last_byte;
               slot_in  = req_ch.root_slot;
               pos_in   = req_ch.position;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (op_ff)
               OP_ROOT: begin
                  if (int'(slot_ff) < MAX_ROOTS && int'(pos_ff) < ROOT_BYTES) begin
                     r_we = 1'b1;
                  end
                  r_waddr  = RAW'(int'(slot_ff) * ROOT_BYTES + int'(pos_ff));
                  state_in = S_IDLE;
               end
               OP_READ: begin
                  c_raddr  = PW'(pos_ff);
                  state_in = S_RDW;
               end
               OP_PATH: begin
                  state_in = S_POST;
                  priority if (at_start_ff) begin
                     at_start_in  = 1'b0;
                     canon_len_in = PW'(1);
                     seg_start_in = '0;
                     seg_len_in   = '0;
                     pend_in      = (byte_ff == CH_SLASH) ? ERR_NONE : ERR_NOT_ABS;
                  end else if (pend_ff == ERR_NOT_ABS || pend_ff == ERR_BAD_BYTE) begin
                     pend_in = pend_ff;
                  end else if (!byte_allowed(byte_ff)) begin
                     pend_in = ERR_BAD_BYTE;
                  end else if (pend_ff != ERR_NONE) begin
                     pend_in = pend_ff;
                  end else if (byte_ff == CH_SLASH) begin
                     fin_ret_in = 1'b0;
                     state_in   = S_FIN;
                  end else begin
                     // Append the byte to the open segment.
                     if (seg_len_ff == '0) begin
                        seg_start_in  = new_start;
                        seg_first_in  = byte_ff;
                        seg_second_in = 8'h00;
                     end else if (seg_len_ff == LW'(1)) begin
                        seg_second_in = byte_ff;
                     end
                     seg_last_in = byte_ff;
                     if (int'(wsum) < PATH_BYTES) begin
                        c_we    = 1'b1;
                        c_waddr = PW'(wsum);
                        c_wdata = byte_ff;
                     end
                     if (int'(seg_len_ff) < PATH_BYTES) begin
                        seg_len_in = seg_len_ff + LW'(1);
                     end
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_RDW: begin
            kind_in    = KIND_READ;
            verdict_in = ERR_NONE;
            rdata_in   = (int'(pos_ff) < int'(canon_len_ff)) ? canon_q : 8'h00;
            state_in   = S_OUT;
         end

         S_POST: begin
            state_in = last_ff ? S_FINAL : S_IDLE;
         end

         S_FINAL: begin
            if (pend_ff == ERR_NONE) begin
               fin_ret_in = 1'b1;
               state_in   = S_FIN;
            end else begin
               seg_len_in = '0;
               state_in   = S_VERD;
            end
         end

         // Close the open segment.
         S_FIN: begin
            seg_len_in = '0;
            state_in   = fin_ret_state;
            priority if (seg_len_ff == '0) begin
               state_in = fin_ret_state;
            end else if (seg_len_ff == LW'(1) && seg_first_ff == CH_DOT) begin
               state_in = fin_ret_state;
            end else if (seg_len_ff == LW'(2) && seg_first_ff == CH_DOT &&
                         seg_second_ff == CH_DOT) begin
               if (canon_len_ff > PW'(1)) begin
                  state_in = S_POP_RD;
               end
            end else if (seg_last_ff == CH_DOT || seg_last_ff == CH_SPACE) begin
               pend_in = ERR_DOT_SPACE;
            end else if (int'(fsum) >= PATH_BYTES) begin
               pend_in = ERR_TOO_LONG;
            end else begin
               if (canon_len_ff > PW'(1)) begin
                  c_we    = 1'b1;
                  c_waddr = canon_len_ff;
                  c_wdata = CH_SLASH;
               end
               canon_len_in = PW'(fsum);
            end
         end

         // Walk back over the last segment and its slash.
         S_POP_RD: begin
            if (canon_len_ff > PW'(1)) begin
               c_raddr  = canon_len_ff - PW'(1);
               state_in = S_POP_CHK;
            end else begin
               state_in = fin_ret_state;
            end
         end

         S_POP_CHK: begin
            canon_len_in = canon_len_ff - PW'(1);
            state_in     = (canon_q == CH_SLASH) ? fin_ret_state : S_POP_RD;
         end

         S_VERD: begin
            priority if (pend_ff != ERR_NONE) begin
               kind_in     = KIND_VERDICT;
               verdict_in  = pend_ff;
               rdata_in    = 8'h00;
               at_start_in = 1'b1;
               state_in    = S_OUT;
            end else if (canon_len_ff <= PW'(1)) begin
               kind_in     = KIND_VERDICT;
               verdict_in  = ERR_REFUSED;
               rdata_in    = 8'h00;
               at_start_in = 1'b1;
               state_in    = S_OUT;
            end else begin
               idx_in     = XW'(1);
               alive_in   = '1;
               refused_in = 1'b0;
               state_in   = S_REF_RD;
            end
         end

         // Refused prefixes, one byte a step.
         S_REF_RD: begin
            c_raddr  = PW'(idx_ff);
            state_in = S_REF_CHK;
         end

         S_REF_CHK: begin
            for (int k = 0; k < PFX_COUNT; k++) begin
               if (idx_ff < XW'(pfx_len(2'(k)))) begin
                  alive_in[k] = alive_ff[k] && in_range &&
                                (to_lower(canon_q) == pfx_byte(2'(k), idx_ff[2:0]));
               end else if (idx_ff == XW'(pfx_len(2'(k)))) begin
                  if (alive_ff[k] && (!in_range || canon_q == CH_SLASH)) begin
                     ref_now = 1'b1;
                  end
               end
            end
            refused_in = ref_now;
            idx_in     = idx_ff + XW'(1);
            state_in   = S_REF_RD;
            if (idx_ff == XW'(REF_LAST)) begin
               priority if (ref_now) begin
                  kind_in     = KIND_VERDICT;
                  verdict_in  = ERR_REFUSED;
                  rdata_in    = 8'h00;
                  at_start_in = 1'b1;
                  state_in    = S_OUT;
               end else if (int'(canon_len_ff) < AUDIT_LEN + 1) begin
                  idx_in   = '0;
                  root_in  = '0;
                  base_in  = '0;
                  state_in = S_CON_RD;
               end else begin
                  idx_in   = XW'(canon_len_ff) - XW'(AUDIT_LEN + 1);
                  cnt_in   = '0;
                  state_in = S_AUD_RD;
               end
            end
         end

         // Refused basename: the tail must be a slash and the name.
         S_AUD_RD: begin
            c_raddr  = PW'(idx_ff);
            state_in = S_AUD_CHK;
         end

         S_AUD_CHK: begin
            priority if (to_lower(canon_q) != audit_byte(cnt_ff)) begin
               idx_in   = '0;
               root_in  = '0;
               base_in  = '0;
               state_in = S_CON_RD;
            end else if (cnt_ff == 4'(AUDIT_LEN)) begin
               kind_in     = KIND_VERDICT;
               verdict_in  = ERR_REFUSED;
               rdata_in    = 8'h00;
               at_start_in = 1'b1;
               state_in    = S_OUT;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               idx_in   = idx_ff + XW'(1);
               state_in = S_AUD_RD;
            end
            if (n_roots == '0 && state_in == S_CON_RD) begin
               kind_in     = KIND_VERDICT;
               verdict_in  = ERR_UNCONTAINED;
               rdata_in    = 8'h00;
               at_start_in = 1'b1;
               state_in    = S_OUT;
            end
         end

         // Containment: compare each loaded root against the path.
         S_CON_RD: begin
            if (n_roots == '0) begin
               kind_in     = KIND_VERDICT;
               verdict_in  = ERR_UNCONTAINED;
               rdata_in    = 8'h00;
               at_start_in = 1'b1;
               state_in    = S_OUT;
            end else begin
               c_raddr  = PW'(idx_ff);
               r_raddr  = RAW'(int'(base_ff) + int'(idx_ff));
               state_in = S_CON_CHK;
            end
         end

         S_CON_CHK: begin
            priority if (idx_ff == XW'(ROOT_BYTES) || r_rdata == 8'h00) begin
               if (!in_range || canon_q == CH_SLASH) begin
                  kind_in     = KIND_VERDICT;
                  verdict_in  = (CW'(canon_len_ff) >= CW'(out_cap_ff)) ? ERR_TRUNCATED
                                                                     : ERR_NONE;
                  rdata_in    = 8'h00;
                  at_start_in = 1'b1;
                  state_in    = S_OUT;
               end else begin
                  root_in  = root_ff + RCW'(1);
                  base_in  = base_ff + BW'(ROOT_BYTES);
                  idx_in   = '0;
                  state_in = S_CON_RD;
               end
            end else if (!in_range || canon_q != r_rdata) begin
               root_in  = root_ff + RCW'(1);
               base_in  = base_ff + BW'(ROOT_BYTES);
               idx_in   = '0;
               state_in = S_CON_RD;
            end else begin
               idx_in   = idx_ff + XW'(1);
               state_in = S_CON_RD;
            end
            if (state_in == S_CON_RD && idx_in == '0 && root_in == n_roots) begin
               kind_in     = KIND_VERDICT;
               verdict_in  = ERR_UNCONTAINED;
               rdata_in    = 8'h00;
               at_start_in = 1'b1;
               state_in    = S_OUT;
            end
         end

         S_OUT: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      addr0_in = (c_raddr == '0);
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      op_in_q: begin
         op_ff      <= op_in;
         byte_ff    <= byte_in;
         last_ff    <= last_in;
         slot_ff    <= slot_in;
         pos_ff     <= pos_in;
         idx_ff     <= idx_in;
         cnt_ff     <= cnt_in;
         alive_ff   <= alive_in;
         refused_ff <= refused_in;
         root_ff    <= root_in;
         base_ff    <= base_in;
         addr0_ff   <= addr0_in;
         kind_ff    <= kind_in;
         verdict_ff <= verdict_in;
         rdata_ff   <= rdata_in;
         fin_ret_ff <= fin_ret_in;
      end
      if (reset) begin
         state_ff      <= S_IDLE;
         canon_len_ff  <= PW'(1);
         seg_start_ff  <= '0;
         seg_len_ff    <= '0;
         pend_ff       <= ERR_NONE;
         at_start_ff   <= 1'b1;
         seg_first_ff  <= 8'h00;
         seg_second_ff <= 8'h00;
         seg_last_ff   <= 8'h00;
         root_count_ff <= '0;
         out_cap_ff    <= OUT_CAPACITY_RESET;
      end else begin
         state_ff      <= state_in;
         canon_len_ff  <= canon_len_in;
         seg_start_ff  <= seg_start_in;
         seg_len_ff    <= seg_len_in;
         pend_ff       <= pend_in;
         at_start_ff   <= at_start_in;
         seg_first_ff  <= seg_first_in;
         seg_second_ff <= seg_second_in;
         seg_last_ff   <= seg_last_in;
         root_count_ff <= root_count_in;
         out_cap_ff    <= out_cap_in;
      end
   end

   // The unit never takes a word while a response is pending.
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rsp_ch.valid)
      else $error("request ready while a response is pending");

   // The canonical length stays within the buffer and never drops below the root.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (canon_len_ff != '0) && (int'(canon_len_ff) < PATH_BYTES))
      else $error("canonical length out of range");

   // A delivered verdict rearms the unit for a new path.
   a_verdict_rearm: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.result_kind == KIND_VERDICT) |=> at_start_ff)
      else $error("verdict delivered without rearming path start");

   // Root writes land only inside the table.
   a_root_write: assert property (@(posedge clock) disable iff (reset)
      r_we |-> (int'(slot_ff) < MAX_ROOTS && int'(pos_ff) < ROOT_BYTES))
      else $error("root write outside the table");

endmodule
